// ===== design/ptmap_pkg.sv =====
// ----------------------------------------------------------------------------
// ptmap_pkg
// Shared widths, codes and controller/datapath handshake types for the
// four-level page table mapper.
// ----------------------------------------------------------------------------
package ptmap_pkg;

  // Pool size default
  localparam int POOL_TABLES_DEFAULT = 64;

  // Field widths
  localparam int IDX_W     = 9;
  localparam int VPN_W     = 36;
  localparam int FRAME_W   = 40;
  localparam int FLAGS_W   = 8;
  localparam int ENTRY_W   = 64;
  localparam int STATUS_W  = 2;
  localparam int USE_W     = 7;
  localparam int LEVEL_W   = 2;

  // Configuration port
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 64;
  localparam logic REG_POOL_BASE = 1'b0;

  // Link flags: present and write
  localparam logic [11:0] LINK_FLAGS = 12'h003;

  // Top walk level (level 0 is the leaf table)
  localparam logic [LEVEL_W-1:0] TOP_LEVEL = 2'd3;
  localparam logic [LEVEL_W-1:0] LEAF_LEVEL = 2'd0;

  // Operation codes
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_MAP    = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISSING   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MAPPED    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd3;

  // How a request is closed out
  typedef enum logic [2:0] {
    FIN_NONE,
    FIN_MISSING,
    FIN_EXHAUSTED,
    FIN_READ,
    FIN_WRITE
  } fin_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic mem_read;
    logic descend;
    logic alloc;
    logic clear_step;
    logic link_write;
    fin_t finish;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic entry_zero;
    logic link_ok;
    logic pool_full;
    logic leaf_present;
    logic is_map;
    logic at_leaf;
    logic clear_done;
    logic out_free;
  } sts_t;

endpackage

// ===== design/ptmap_if.sv =====
// ----------------------------------------------------------------------------
// ptmap_req_if / ptmap_rsp_if
// Valid/ready channels carrying mapper requests and results.
// ----------------------------------------------------------------------------
interface ptmap_req_if;
  logic                              valid;
  logic                              ready;
  logic                              operation;
  logic [ptmap_pkg::VPN_W-1:0]       virtual_page;
  logic [ptmap_pkg::FRAME_W-1:0]     physical_page;
  logic [ptmap_pkg::FLAGS_W-1:0]     page_flags;
  logic                              last_page;

  modport source (
    output valid, operation, virtual_page, physical_page, page_flags, last_page,
    input  ready
  );
  modport sink (
    input  valid, operation, virtual_page, physical_page, page_flags, last_page,
    output ready
  );
endinterface

interface ptmap_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [ptmap_pkg::STATUS_W-1:0]    status;
  logic [ptmap_pkg::ENTRY_W-1:0]     entry_value;
  logic [ptmap_pkg::USE_W-1:0]       tables_in_use;
  logic                              last;

  modport source (
    output valid, status, entry_value, tables_in_use, last,
    input  ready
  );
  modport sink (
    input  valid, status, entry_value, tables_in_use, last,
    output ready
  );
endinterface

// ===== design/four_level_page_table_mapper_top.sv =====
// ----------------------------------------------------------------------------
// four_level_page_table_mapper_top
// Four-level page table mapper over a pool of 512-entry tables.
// ----------------------------------------------------------------------------
// After reset the block clears the root table, one entry a cycle, and takes
// no request until that sweep is done. A request then passes through the
// accept cycle and up to four table reads, each a read-issue and an evaluate
// cycle on the single-ported table store; its close waits while the output
// register is full. Each table a map has to create adds a clear sweep of all
// 512 entries of the new table and the link write. A result waits in an output
// register, so the next request is taken while it is still pending.
// The pool base frame may be written only while no request is in flight.
module four_level_page_table_mapper_top #(
  parameter int POOL_TABLES = ptmap_pkg::POOL_TABLES_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  ptmap_req_if.sink                           req,
  ptmap_rsp_if.source                         rsp,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ptmap_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [ptmap_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [ptmap_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                pready
);

  logic [ptmap_pkg::FRAME_W-1:0] pool_base;
  logic                          reg_hit;
  ptmap_pkg::cmd_t               cmd;
  ptmap_pkg::sts_t               sts;

  // Register file
  assign pready  = 1'b1;
  assign reg_hit = (paddr[3] == ptmap_pkg::REG_POOL_BASE);
  assign prdata  = reg_hit ? ptmap_pkg::APB_DATA_W'(pool_base) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base <= '0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      pool_base <= pwdata[ptmap_pkg::FRAME_W-1:0];
    end
  end

  ptmap_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ptmap_dp #(
    .POOL_TABLES (POOL_TABLES)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .pool_base         (pool_base),
    .in_operation      (req.operation),
    .in_virtual_page   (req.virtual_page),
    .in_physical_page  (req.physical_page),
    .in_page_flags     (req.page_flags),
    .in_last_page      (req.last_page),
    .out_valid         (rsp.valid),
    .out_ready         (rsp.ready),
    .out_status        (rsp.status),
    .out_entry_value   (rsp.entry_value),
    .out_tables_in_use (rsp.tables_in_use),
    .out_last          (rsp.last)
  );

endmodule

// ===== design/ptmap_ctrl.sv =====
// ----------------------------------------------------------------------------
// ptmap_ctrl
// Walk sequencer: clears the root after reset, then steps each request
// through up to four table reads, table allocation for maps and the leaf update.
// ----------------------------------------------------------------------------
module ptmap_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  ptmap_pkg::sts_t sts,
  output ptmap_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_READ,
    S_EVAL,
    S_CLEAR,
    S_LINK
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  // Decode commands and next state
  always_comb begin
    cmd        = '0;
    cmd.finish = ptmap_pkg::FIN_NONE;
    state_next = state;
    case (state)
      S_INIT: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_READ;
        end
      end
      S_READ: begin
        cmd.mem_read = 1'b1;
        state_next   = S_EVAL;
      end
      S_EVAL: begin
        if (sts.at_leaf) begin
          if (sts.out_free) begin
            cmd.finish = (sts.is_map && !sts.leaf_present) ?
                         ptmap_pkg::FIN_WRITE : ptmap_pkg::FIN_READ;
            state_next = S_IDLE;
          end
        end else if (sts.entry_zero) begin
          if (!sts.is_map) begin
            if (sts.out_free) begin
              cmd.finish = ptmap_pkg::FIN_MISSING;
              state_next = S_IDLE;
            end
          end else if (sts.pool_full) begin
            if (sts.out_free) begin
              cmd.finish = ptmap_pkg::FIN_EXHAUSTED;
              state_next = S_IDLE;
            end
          end else begin
            cmd.alloc  = 1'b1;
            state_next = S_CLEAR;
          end
        end else if (!sts.link_ok) begin
          if (sts.out_free) begin
            cmd.finish = ptmap_pkg::FIN_MISSING;
            state_next = S_IDLE;
          end
        end else begin
          cmd.descend = 1'b1;
          state_next  = S_READ;
        end
      end
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_done) state_next = S_LINK;
      end
      S_LINK: begin
        cmd.link_write = 1'b1;
        state_next     = S_READ;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== design/ptmap_dp.sv =====
// ----------------------------------------------------------------------------
// ptmap_dp
// Mapper datapath: table store, walk registers, allocation counter, table
// clear sweep and the result register.
// ----------------------------------------------------------------------------
module ptmap_dp #(
  parameter int POOL_TABLES = ptmap_pkg::POOL_TABLES_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  ptmap_pkg::cmd_t                    cmd,
  output ptmap_pkg::sts_t                    sts,
  input  logic [ptmap_pkg::FRAME_W-1:0]      pool_base,
  // request payload
  input  logic                               in_operation,
  input  logic [ptmap_pkg::VPN_W-1:0]        in_virtual_page,
  input  logic [ptmap_pkg::FRAME_W-1:0]      in_physical_page,
  input  logic [ptmap_pkg::FLAGS_W-1:0]      in_page_flags,
  input  logic                               in_last_page,
  // result register
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [ptmap_pkg::STATUS_W-1:0]     out_status,
  output logic [ptmap_pkg::ENTRY_W-1:0]      out_entry_value,
  output logic [ptmap_pkg::USE_W-1:0]        out_tables_in_use,
  output logic                               out_last
);

  localparam int TW    = $clog2(POOL_TABLES);
  localparam int NFW   = TW + 1;
  localparam int AW    = TW + ptmap_pkg::IDX_W;
  localparam int DEPTH = POOL_TABLES << ptmap_pkg::IDX_W;
  localparam logic [NFW-1:0] POOL_COUNT = NFW'(POOL_TABLES);

  logic [ptmap_pkg::ENTRY_W-1:0] mem [DEPTH];

  // captured request
  logic                          op;
  logic [ptmap_pkg::VPN_W-1:0]   vp;
  logic [ptmap_pkg::FRAME_W-1:0] phys;
  logic [ptmap_pkg::FLAGS_W-1:0] flags;
  logic                          last_q;

  // walk state
  logic [ptmap_pkg::LEVEL_W-1:0] level;
  logic [TW-1:0]                 tbl;
  logic [ptmap_pkg::ENTRY_W-1:0] rdata;
  logic [NFW-1:0]                next_free;
  logic [TW-1:0]                 clr_tbl;
  logic [ptmap_pkg::IDX_W-1:0]   clr_cnt;

  logic [ptmap_pkg::IDX_W-1:0]   idx;
  logic [ptmap_pkg::FRAME_W-1:0] k_calc;
  logic [ptmap_pkg::ENTRY_W-1:0] link_entry;
  logic [ptmap_pkg::ENTRY_W-1:0] leaf_entry;
  logic                          wr_en;
  logic [AW-1:0]                 wr_addr;
  logic [ptmap_pkg::ENTRY_W-1:0] wr_data;
  logic                          out_load;

  // Index of the current level
  assign idx = vp[level * ptmap_pkg::IDX_W +: ptmap_pkg::IDX_W];

  // Table number named by a link, relative to the pool base
  assign k_calc = rdata[ptmap_pkg::FRAME_W+11:12] - pool_base;

  assign link_entry = {12'h000, pool_base + ptmap_pkg::FRAME_W'(clr_tbl),
                       ptmap_pkg::LINK_FLAGS};
  assign leaf_entry = {12'h000, phys, 4'h0, flags};

  // Status to the sequencer
  always_comb begin
    sts.entry_zero   = (rdata == '0);
    sts.link_ok      = (k_calc < ptmap_pkg::FRAME_W'(next_free));
    sts.pool_full    = (next_free >= POOL_COUNT);
    sts.leaf_present = rdata[0];
    sts.is_map       = (op == ptmap_pkg::OP_MAP);
    sts.at_leaf      = (level == ptmap_pkg::LEAF_LEVEL);
    sts.clear_done   = &clr_cnt;
    sts.out_free     = !out_valid || out_ready;
  end

  // Select the single write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {tbl, idx};
    wr_data = leaf_entry;
    if (cmd.clear_step) begin
      wr_en   = 1'b1;
      wr_addr = {clr_tbl, clr_cnt};
      wr_data = '0;
    end else if (cmd.link_write) begin
      wr_en   = 1'b1;
      wr_data = link_entry;
    end else if (cmd.finish == ptmap_pkg::FIN_WRITE) begin
      wr_en   = 1'b1;
    end
  end

  assign out_load = (cmd.finish != ptmap_pkg::FIN_NONE);

  // Table store
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.mem_read) rdata <= mem[{tbl, idx}];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      next_free <= NFW'(1);
      clr_tbl   <= '0;
      clr_cnt   <= '0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (cmd.alloc) begin
        next_free <= next_free + NFW'(1);
        clr_tbl   <= next_free[TW-1:0];
        clr_cnt   <= '0;
      end else if (cmd.clear_step) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  // Request capture and walk position
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op     <= in_operation;
      vp     <= in_virtual_page;
      phys   <= in_physical_page;
      flags  <= in_page_flags;
      last_q <= in_last_page;
      level  <= ptmap_pkg::TOP_LEVEL;
      tbl    <= '0;
    end else if (cmd.descend) begin
      level <= level - 1'b1;
      tbl   <= k_calc[TW-1:0];
    end else if (cmd.link_write) begin
      level <= level - 1'b1;
      tbl   <= clr_tbl;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tables_in_use <= ptmap_pkg::USE_W'(next_free);
      out_last          <= last_q;
      case (cmd.finish)
        ptmap_pkg::FIN_READ: begin
          out_status      <= (op == ptmap_pkg::OP_MAP && rdata[0]) ?
                             ptmap_pkg::ST_MAPPED : ptmap_pkg::ST_OK;
          out_entry_value <= rdata;
        end
        ptmap_pkg::FIN_WRITE: begin
          out_status      <= ptmap_pkg::ST_OK;
          out_entry_value <= leaf_entry;
        end
        ptmap_pkg::FIN_EXHAUSTED: begin
          out_status      <= ptmap_pkg::ST_EXHAUSTED;
          out_entry_value <= '0;
        end
        default: begin
          out_status      <= ptmap_pkg::ST_MISSING;
          out_entry_value <= '0;
        end
      endcase
    end
  end

endmodule
